FILE: rtl/pdrr_pkg.sv
// Shared constants for the point-to-plane RMS roughness core.
// Field widths, configuration register indexes and reset values.
// No dependencies.
`default_nettype none

package pdrr_pkg;

	// Field widths
	localparam int COORD_W = 24;
	localparam int NORM_W  = 16;
	localparam int DIST_W  = 23;
	localparam int SCORE_W = 17;
	localparam int CNT_W   = 17;
	localparam int SUM_W   = 64;
	localparam int DOT_W   = 42;

	// Stream and configuration port widths
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Inlier accumulation limit
	localparam logic [CNT_W-1:0] MAX_POINTS = 17'd65536;

	// Score of 1.0 in Q1.16
	localparam logic [SCORE_W-1:0] SCORE_ONE = 17'd65536;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_X  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Y  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTROID_Z  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INLIER_LIM  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROUGH   = 3'd7;

	// Reset values
	localparam logic [NORM_W-1:0] NORMAL_Z_RST     = 16'd16384;
	localparam logic [DIST_W-1:0] INLIER_LIM_RST   = 23'd13107;
	localparam logic [DIST_W-1:0] MAX_ROUGH_RST    = 23'd3277;

endpackage

`default_nettype wire

FILE: rtl/plane_distance_rms_roughness_core.sv
// Point-to-plane RMS roughness core: per-point distance, inlier test and cloud score.
// One multiplier and one compare-subtract unit shared under a small sequencer.
// Depends on pdrr_pkg.
//
// Usage:
//  Points arrive on the s_axis channel, one word per point; s_axis_tlast marks the
//  final point of a cloud. Every point gives one word on the m_axis channel holding
//  its distance to the plane and its inlier flag; the word for the final point also
//  carries the score and no-inlier flag, with m_axis_tlast high.
//  Plane centroid, normal, inlier limit and maximum roughness are written through
//  cfg_we / cfg_index / cfg_data; the user must write them only while no point is
//  in flight, and the core has no check for it. A point passes three times through
//  the shared multiplier, once per axis, and once more for the squaring pass before
//  its result word. The final point of a cloud, unless it has no inliers, adds a
//  64-step division of the square sum by the inlier count, a 32-step square root and
//  a 64-step division by the maximum roughness, all on the shared compare-subtract
//  unit, one bit per cycle. s_axis_tready is high only while the sequencer is idle,
//  so a new point is taken only once the previous result word is in the output register.
//  A result word sits in an output register; when the receiver stalls, the next
//  point is still taken and worked on, and its result waits until the register frees.
//  Reset clears the sums, the sequencer and the output valid, and loads the
//  configuration reset values (normal pointing along z).
`default_nettype none

module plane_distance_rms_roughness_core (
	input  wire                               clk,
	input  wire                               arst_n,
	// s_axis_tdata: point_x[23:0], point_y[47:24], point_z[71:48]
	input  wire                               s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire [pdrr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	input  wire                               s_axis_tlast,
	// m_axis_tdata: distance[22:0], is_inlier[23], score[40:24], no_inliers[41], zero[47:42]
	output logic                              m_axis_tvalid,
	input  wire                               m_axis_tready,
	output logic [pdrr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	input  wire                               cfg_we,
	input  wire [pdrr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [pdrr_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pdrr_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_ADD  = 4'd2;
	localparam logic [3:0] ST_DIST = 4'd3;
	localparam logic [3:0] ST_SQ   = 4'd4;
	localparam logic [3:0] ST_ACC  = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_DIV1 = 4'd7;
	localparam logic [3:0] ST_SQRT = 4'd8;
	localparam logic [3:0] ST_DIV2 = 4'd9;
	localparam logic [3:0] ST_OUT  = 4'd10;

	localparam logic [1:0] AXIS_LAST = 2'd2;
	localparam logic [5:0] DIV_LAST  = 6'd63;
	localparam logic [5:0] SQRT_LAST = 6'd31;

	// Configuration registers
	logic [COORD_W-1:0] cx_q, cy_q, cz_q;
	logic [NORM_W-1:0]  nx_q, ny_q, nz_q;
	logic [DIST_W-1:0]  inlier_lim_q, max_rough_q;

	// Sequencer and point registers
	logic [3:0]         state_q;
	logic [1:0]         axis_q;
	logic [5:0]         step_q;
	logic [COORD_W-1:0] px_q, py_q, pz_q;
	logic               last_q;
	logic signed [48:0] prod_q;
	logic signed [DOT_W-1:0] dot_q;
	logic [DIST_W-1:0]  dist_q;
	logic               inl_q;
	logic [SUM_W-1:0]   square_sum_q;
	logic [CNT_W-1:0]   inlier_count_q;

	// Shared divide / square-root datapath
	logic [SUM_W-1:0]   acc_q;
	logic [SUM_W-1:0]   rem_q;
	logic [SUM_W-1:0]   bit_q;
	logic [DIST_W-1:0]  divisor_q;
	logic [SCORE_W-1:0] score_q;
	logic               none_q;

	// Output register
	logic               m_valid_q;
	logic [DIST_W-1:0]  o_dist_q;
	logic               o_inl_q;
	logic               o_last_q;
	logic [SCORE_W-1:0] o_score_q;
	logic               o_none_q;

	logic                    accept;
	logic                    out_load;
	logic [COORD_W-1:0]      p_sel, c_sel;
	logic [NORM_W-1:0]       n_sel;
	logic [COORD_W:0]        diff;
	logic signed [24:0]      mul_a;
	logic signed [23:0]      mul_b;
	logic signed [48:0]      mul_p;
	logic [DOT_W-1:0]        dot_u, mag;
	logic [DOT_W:0]          rnd;
	logic [28:0]             dist_full;
	logic [DIST_W-1:0]       dist_sat;
	logic [SUM_W:0]          sum_ext;
	logic [SUM_W-1:0]        sub_a, sub_b;
	logic [SUM_W:0]          sub_d;
	logic                    sub_ge;
	logic [SUM_W-1:0]        rem_sh;
	logic [SUM_W-1:0]        div_acc_nx, div_rem_nx;
	logic [SUM_W-1:0]        sqrt_res_nx, sqrt_v_nx;
	logic [SUM_W-1:0]        quot2;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

	// Select the axis for the dot product
	always_comb begin
		case (axis_q)
			2'd0: begin
				p_sel = px_q; c_sel = cx_q; n_sel = nx_q;
			end
			2'd1: begin
				p_sel = py_q; c_sel = cy_q; n_sel = ny_q;
			end
			default: begin
				p_sel = pz_q; c_sel = cz_q; n_sel = nz_q;
			end
		endcase
	end

	assign diff = {p_sel[COORD_W-1], p_sel} - {c_sel[COORD_W-1], c_sel};

	// Shared multiplier: normal times offset, or distance squared
	always_comb begin
		if (state_q == ST_SQ) begin
			mul_a = $signed({2'b00, dist_q});
			mul_b = $signed({1'b0, dist_q});
		end else begin
			mul_a = $signed(diff);
			mul_b = $signed({{8{n_sel[NORM_W-1]}}, n_sel});
		end
	end
	assign mul_p = mul_a * mul_b;

	// Magnitude, round half up to Q.16, saturate
	assign dot_u     = dot_q;
	assign mag       = dot_q[DOT_W-1] ? (~dot_u + 42'd1) : dot_u;
	assign rnd       = {1'b0, mag} + 43'd8192;
	assign dist_full = rnd[42:14];
	assign dist_sat  = (|dist_full[28:23]) ? {DIST_W{1'b1}} : dist_full[22:0];

	// Saturating square accumulate
	assign sum_ext = {1'b0, square_sum_q} + {18'd0, prod_q[45:0]};

	// Shared compare-subtract unit
	assign rem_sh = {rem_q[SUM_W-2:0], acc_q[SUM_W-1]};
	always_comb begin
		if (state_q == ST_SQRT) begin
			sub_a = rem_q;
			sub_b = acc_q | bit_q;
		end else begin
			sub_a = rem_sh;
			sub_b = {41'd0, divisor_q};
		end
	end
	assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_ge = !sub_d[SUM_W];

	// Next values of one restoring division step and one square-root step
	assign div_acc_nx  = {acc_q[SUM_W-2:0], sub_ge};
	assign div_rem_nx  = sub_ge ? sub_d[SUM_W-1:0] : rem_sh;
	assign sqrt_v_nx   = sub_ge ? sub_d[SUM_W-1:0] : rem_q;
	assign sqrt_res_nx = sub_ge ? ((acc_q >> 1) | bit_q) : (acc_q >> 1);
	assign quot2       = div_acc_nx;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
			nx_q         <= '0;
			ny_q         <= '0;
			nz_q         <= NORMAL_Z_RST;
			inlier_lim_q <= INLIER_LIM_RST;
			max_rough_q  <= MAX_ROUGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTROID_X: cx_q         <= cfg_data;
				REG_CENTROID_Y: cy_q         <= cfg_data;
				REG_CENTROID_Z: cz_q         <= cfg_data;
				REG_NORMAL_X:   nx_q         <= cfg_data[NORM_W-1:0];
				REG_NORMAL_Y:   ny_q         <= cfg_data[NORM_W-1:0];
				REG_NORMAL_Z:   nz_q         <= cfg_data[NORM_W-1:0];
				REG_INLIER_LIM: inlier_lim_q <= cfg_data[DIST_W-1:0];
				REG_MAX_ROUGH:  max_rough_q  <= cfg_data[DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// Point registers
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= s_axis_tdata[23:0];
			py_q   <= s_axis_tdata[47:24];
			pz_q   <= s_axis_tdata[71:48];
			last_q <= s_axis_tlast;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			axis_q         <= '0;
			step_q         <= '0;
			square_sum_q   <= '0;
			inlier_count_q <= '0;
			m_valid_q      <= 1'b0;
		end else begin
			// load a new output word, or drop the current one once taken
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						axis_q  <= '0;
						dot_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= mul_p;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					dot_q  <= dot_q + $signed(prod_q[DOT_W-1:0]);
					axis_q <= axis_q + 2'd1;
					state_q <= (axis_q == AXIS_LAST) ? ST_DIST : ST_MUL;
				end
				ST_DIST: begin
					dist_q  <= dist_sat;
					inl_q   <= dist_sat < inlier_lim_q;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					prod_q  <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					// accumulate inliers until the count limit
					if (inl_q && (inlier_count_q < MAX_POINTS)) begin
						square_sum_q   <= sum_ext[SUM_W] ? {SUM_W{1'b1}}
						                                 : sum_ext[SUM_W-1:0];
						inlier_count_q <= inlier_count_q + 17'd1;
					end
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					score_q <= '0;
					none_q  <= 1'b0;
					if (!last_q) begin
						state_q <= ST_OUT;
					end else begin
						// final point: start the score, or flag no inliers, and clear the sums
						if (inlier_count_q == '0) begin
							none_q  <= 1'b1;
							state_q <= ST_OUT;
						end else begin
							acc_q     <= square_sum_q;
							rem_q     <= '0;
							divisor_q <= {6'd0, inlier_count_q};
							step_q    <= '0;
							state_q   <= ST_DIV1;
						end
						square_sum_q   <= '0;
						inlier_count_q <= '0;
					end
				end
				ST_DIV1: begin
					step_q <= step_q + 6'd1;
					if (step_q == DIV_LAST) begin
						// mean square becomes the square-root operand
						rem_q   <= div_acc_nx;
						acc_q   <= '0;
						bit_q   <= {2'b01, 62'd0};
						state_q <= ST_SQRT;
					end else begin
						acc_q <= div_acc_nx;
						rem_q <= div_rem_nx;
					end
				end
				ST_SQRT: begin
					bit_q  <= bit_q >> 2;
					if (step_q == SQRT_LAST) begin
						acc_q     <= {16'd0, sqrt_res_nx[31:0], 16'd0};
						rem_q     <= '0;
						divisor_q <= max_rough_q;
						step_q    <= '0;
						state_q   <= ST_DIV2;
					end else begin
						step_q <= step_q + 6'd1;
						acc_q  <= sqrt_res_nx;
						rem_q  <= sqrt_v_nx;
					end
				end
				ST_DIV2: begin
					step_q <= step_q + 6'd1;
					acc_q  <= div_acc_nx;
					rem_q  <= div_rem_nx;
					if (step_q == DIV_LAST) begin
						// clamp to 1.0
						score_q <= (quot2 > {47'd0, SCORE_ONE}) ? SCORE_ONE
						                                        : quot2[SCORE_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold until the output register frees
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_dist_q  <= dist_q;
			o_inl_q   <= inl_q;
			o_last_q  <= last_q;
			o_score_q <= score_q;
			o_none_q  <= none_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {6'd0, o_none_q, o_score_q, o_inl_q, o_dist_q};

endmodule

`default_nettype wire
